@@ src/atapio_pkg.sv @@
package atapio_pkg;

    localparam int unsigned WordsPerSector = 256;
    localparam int unsigned WordIdxW       = $clog2(WordsPerSector);
    localparam int unsigned SectorW        = 28;

    // input command codes
    localparam logic [2:0] CMD_BYTE_RD = 3'd0;
    localparam logic [2:0] CMD_BYTE_WR = 3'd1;
    localparam logic [2:0] CMD_DATA_RD = 3'd2;
    localparam logic [2:0] CMD_DATA_WR = 3'd3;
    localparam logic [2:0] CMD_ALT_RD  = 3'd4;
    localparam logic [2:0] CMD_ALT_WR  = 3'd5;
    localparam logic [2:0] CMD_FILL    = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_CYL   = 2'd0;
    localparam logic [1:0] CFG_HEADS = 2'd1;
    localparam logic [1:0] CFG_SPT   = 2'd2;

    // ATA opcodes and status values
    localparam logic [7:0] ATA_READ     = 8'h20;
    localparam logic [7:0] ATA_READ_EXT = 8'h28;
    localparam logic [7:0] ATA_WRITE    = 8'h30;
    localparam logic [7:0] ATA_IDENTIFY = 8'hec;
    localparam logic [7:0] ST_READY     = 8'h50;
    localparam logic [7:0] ST_DRQ       = 8'h08;
    localparam logic [7:0] ST_SLAVE     = 8'h01;
    localparam logic [7:0] ERR_SLAVE    = 8'h02;

    localparam logic [1:0] REQ_NONE   = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_COMMIT = 2'd2;

    // beat layouts
    typedef struct packed {
        logic [7:0]  fill_index;
        logic [15:0] write_data;
        logic [2:0]  reg_addr;
        logic [2:0]  command;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  disk_word_index;
        logic [15:0] disk_word;
        logic        disk_word_valid;
        logic [27:0] disk_sector;
        logic [1:0]  disk_request;
        logic        irq_pulse;
        logic [15:0] read_data;
    } t_out_item;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // latch input beat, decode
        logic mul1;      // c*heads
        logic mul2;      // *spt, h*spt
        logic finish;    // update state, build result
    } t_dp_cmd;

    typedef struct packed {
        logic chs_needed;  // item is a read/write command in CHS mode
    } t_dp_status;

    // identify table; config-dependent words are patched in the datapath
    function automatic logic [15:0] identify_const(input logic [7:0] i);
        logic [15:0] w;
        begin
            w = 16'h0000;
            case (i)
                8'd49: w = 16'h0200;
                8'd10, 8'd23: w = 16'h3231;  // "12"
                8'd11, 8'd24: w = 16'h3433;  // "34"
                8'd27: w = 16'h6953;  // "Si"
                8'd28: w = 16'h756d;  // "mu"
                8'd29: w = 16'h616c;  // "la"
                8'd30: w = 16'h6574;  // "te"
                8'd31: w = 16'h2064;  // "d "
                8'd32: w = 16'h4449;  // "ID"
                8'd33: w = 16'h0045;  // "E"
                default: w = 16'h0000;
            endcase
            return w;
        end
    endfunction

endpackage

@@ src/ata_pio_disk_device.sv @@
// ATA PIO task-file device, disk side.
// Input stream (s_axis): one beat per bus access or disk fill. tdata carries
//   command, reg_addr, write_data and fill_index from the low bit up.
// Output stream (m_axis): exactly one beat per input beat, carrying the read
//   value, interrupt pulse, disk request and sector, and any host data word
//   stored for the disk.
// Config port: i_cfg_we with index 0 cylinders, 1 heads, 2 sectors per track.
// Timing: an accepted item passes through decode and finish, and for a CHS
//   read/write command also through two registered multiply stages between
//   them, where the sector number is built. The controller is back in idle as
//   the result appears, so it takes no new item before the last is through.
// The result sits in an output register; a new item is accepted while it
//   waits only if it is being taken that cycle, so a stalled receiver stops
//   input after one held beat.
// Reset (synchronous, i_rst_n low) gives status 0x50, master selected, task
//   file cleared, 16 heads, 63 sectors per track. Sector buffer words are
//   undefined until filled or written.
module ata_pio_disk_device (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // command, reg_addr, write_data, fill_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data, irq_pulse, disk_request, disk_sector, disk_word_valid,
    // disk_word, disk_word_index
    output logic [71:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);
    import atapio_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_out_item  w_out;

    atapio_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    atapio_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_item     (t_in_item'(s_axis_tdata[29:0])),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_item     (w_out)
    );

    assign m_axis_tdata = w_out;
endmodule

@@ src/atapio_ram.sv @@
module atapio_ram #(
    parameter int unsigned Width = 16,
    parameter int unsigned Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/atapio_ctrl.sv @@
module atapio_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  atapio_pkg::t_dp_status  i_status,
    output atapio_pkg::t_dp_cmd     o_cmd
);
    import atapio_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEC  = 5'b00010,
        S_MUL1 = 5'b00100,
        S_MUL2 = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // accept in idle when the output register is empty or drains this cycle
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: if (i_in_valid && o_in_ready) n_state = S_DEC;
            S_DEC:  n_state = i_status.chs_needed ? S_MUL1 : S_FIN;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_FIN;
            S_FIN: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid && o_in_ready;
    assign o_cmd.mul1   = (r_state == S_MUL1);
    assign o_cmd.mul2   = (r_state == S_MUL2);
    assign o_cmd.finish = (r_state == S_FIN);

    // a result only appears as an item finishes
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result without finish");
    // no item taken while a result is held and not drained
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("overrun");
    // multiply stages follow in order
    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1) |=> (r_state == S_MUL2))
        else $error("mul order");
endmodule

@@ src/atapio_dp.sv @@
module atapio_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  atapio_pkg::t_dp_cmd     i_cmd,
    output atapio_pkg::t_dp_status  o_status,
    input  atapio_pkg::t_in_item    i_item,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_addr,
    input  logic [15:0]             i_cfg_data,
    output atapio_pkg::t_out_item   o_item
);
    import atapio_pkg::*;

    // configuration
    logic [15:0] r_cyl_count;
    logic [4:0]  r_heads;
    logic [5:0]  r_spt;
    // device state
    logic [7:0]         r_status, n_status;
    logic [7:0]         r_error, n_error;
    logic [7:0]         r_tf [5];
    logic [7:0]         n_tf [5];
    logic               r_slave, n_slave;
    logic [SectorW-1:0] r_cur, n_cur;
    logic [WordIdxW-1:0] r_pos, n_pos;
    logic               r_ident, n_ident;
    // latched beat and CHS products
    t_in_item    r_in;
    logic [20:0] r_ch;
    logic [SectorW-1:0] r_chs;
    t_out_item   r_out, n_out;

    logic [15:0] w_rdata;
    logic        w_ram_we;
    logic [WordIdxW-1:0] w_ram_waddr;

    logic [7:0] w_bdata;
    logic       w_cmd_ok;
    logic       w_is_rw;
    assign w_bdata  = r_in.write_data[7:0];
    assign w_cmd_ok = (r_in.command == CMD_BYTE_WR) && (r_in.reg_addr == 3'd7) && !r_slave;
    assign w_is_rw  = (w_bdata == ATA_READ) || (w_bdata == ATA_READ_EXT)
                    || (w_bdata == ATA_WRITE);
    assign o_status.chs_needed = w_cmd_ok && w_is_rw && !r_tf[4][6];

    // buffer: host data writes at the word position, disk fills at fill_index
    assign w_ram_we = i_cmd.finish && ((r_in.command == CMD_FILL) ||
        ((r_in.command == CMD_DATA_WR) && (r_in.reg_addr == 3'd0)
         && r_status[3] && !r_ident));
    assign w_ram_waddr = (r_in.command == CMD_FILL) ? r_in.fill_index : r_pos;

    atapio_ram #(.Width(16), .Depth(WordsPerSector)) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (r_in.write_data),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cyl_count <= 16'd0;
            r_heads     <= 5'd16;
            r_spt       <= 6'd63;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CYL:   r_cyl_count <= i_cfg_data;
                CFG_HEADS: r_heads     <= i_cfg_data[4:0];
                CFG_SPT:   r_spt       <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // CHS translation over two multiply stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        if (i_cmd.mul1) begin
            r_ch <= {r_tf[3], r_tf[2]} * r_heads;
        end
        if (i_cmd.mul2) begin
            r_chs <= SectorW'(r_ch * r_spt)
                   + SectorW'({6'd0, r_tf[4][3:0]} * r_spt)
                   + SectorW'(r_tf[1][5:0]) - SectorW'(1);
        end
    end

    function automatic logic [15:0] ident_word(input logic [7:0] i, input logic [15:0] cyl,
                                               input logic [4:0] hd, input logic [5:0] sp);
        logic [15:0] w;
        begin
            w = identify_const(i);
            if (i == 8'd1) w = cyl;
            if (i == 8'd3) w = {11'd0, hd};
            if (i == 8'd6) w = {10'd0, sp};
            return w;
        end
    endfunction

    // state update and result
    always_comb begin
        logic [SectorW-1:0] sec;
        logic [7:0] cnt;
        logic       sel;
        logic       last;
        n_status = r_status;
        n_error  = r_error;
        for (int k = 0; k < 5; k++) n_tf[k] = r_tf[k];
        n_slave  = r_slave;
        n_cur    = r_cur;
        n_pos    = r_pos;
        n_ident  = r_ident;
        n_out    = '0;
        sec = r_tf[4][6] ? {r_tf[4][3:0], r_tf[3], r_tf[2], r_tf[1]} : r_chs;
        cnt  = r_tf[0] - 8'd1;
        last = (r_pos == WordIdxW'(WordsPerSector - 1));
        sel  = 1'b0;
        case (r_in.command)
            CMD_BYTE_RD: begin
                case (r_in.reg_addr)
                    3'd1: n_out.read_data = {8'd0, r_error};
                    3'd2, 3'd3, 3'd4, 3'd5, 3'd6:
                        n_out.read_data = {8'd0, r_tf[r_in.reg_addr - 3'd2]};
                    3'd7: n_out.read_data = {8'd0, r_status};
                    default: n_out.read_data = 16'hffff;
                endcase
            end
            CMD_BYTE_WR: begin
                if (r_in.reg_addr inside {[3'd2:3'd6]}) begin
                    n_tf[r_in.reg_addr - 3'd2] = w_bdata;
                    sel = n_tf[4][4];
                    if (sel != r_slave) begin
                        n_slave = sel;
                        n_status = sel ? ST_SLAVE : ST_READY;
                        n_error  = sel ? ERR_SLAVE : 8'd0;
                    end
                end else if (w_cmd_ok) begin
                    n_error  = 8'd0;
                    n_status = ST_READY;
                    n_pos    = '0;
                    n_ident  = 1'b0;
                    if (w_is_rw) begin
                        n_cur = sec;
                        if (r_tf[0] != 8'd0) begin
                            n_status = ST_DRQ;
                            if (w_bdata != ATA_WRITE) begin
                                n_out.disk_request = REQ_READ;
                                n_out.disk_sector  = sec;
                                n_out.irq_pulse    = 1'b1;
                            end
                        end
                    end else if (w_bdata == ATA_IDENTIFY) begin
                        n_ident  = 1'b1;
                        n_status = ST_DRQ;
                        n_out.irq_pulse = 1'b1;
                    end
                end
            end
            CMD_DATA_RD: begin
                if (r_in.reg_addr != 3'd0 || !r_status[3]) begin
                    n_out.read_data = 16'hffff;
                end else begin
                    n_out.read_data = r_ident
                        ? ident_word(r_pos, r_cyl_count, r_heads, r_spt) : w_rdata;
                    n_pos = r_pos + 1'b1;
                    if (last) begin
                        if (r_ident) begin
                            n_ident  = 1'b0;
                            n_status = ST_READY;
                        end else begin
                            n_tf[0] = cnt;
                            if (cnt != 8'd0) begin
                                n_cur = r_cur + 1'b1;
                                n_out.disk_request = REQ_READ;
                                n_out.disk_sector  = r_cur + 1'b1;
                                n_out.irq_pulse    = 1'b1;
                            end else begin
                                n_status = ST_READY;
                            end
                        end
                    end
                end
            end
            CMD_DATA_WR: begin
                if (r_in.reg_addr == 3'd0 && r_status[3] && !r_ident) begin
                    n_out.disk_word_valid = 1'b1;
                    n_out.disk_word       = r_in.write_data;
                    n_out.disk_word_index = r_pos;
                    n_pos = r_pos + 1'b1;
                    if (last) begin
                        n_out.disk_request = REQ_COMMIT;
                        n_out.disk_sector  = r_cur;
                        n_out.irq_pulse    = 1'b1;
                        n_tf[0] = cnt;
                        if (cnt != 8'd0) n_cur = r_cur + 1'b1;
                        else n_status = ST_READY;
                    end
                end
            end
            CMD_ALT_RD: n_out.read_data = {8'd0, (r_in.reg_addr != 3'd0) ? r_error : r_status};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_READY;
            r_error  <= 8'd0;
            for (int k = 0; k < 5; k++) r_tf[k] <= 8'd0;
            r_slave  <= 1'b0;
            r_cur    <= '0;
            r_pos    <= '0;
            r_ident  <= 1'b0;
        end else if (i_cmd.finish) begin
            r_status <= n_status;
            r_error  <= n_error;
            for (int k = 0; k < 5; k++) r_tf[k] <= n_tf[k];
            r_slave  <= n_slave;
            r_cur    <= n_cur;
            r_pos    <= n_pos;
            r_ident  <= n_ident;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) r_out <= n_out;
    end
    assign o_item = r_out;

    // selecting the slave always reports the slave error pair
    a_slave_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !r_slave && n_slave) |=> (r_status == ST_SLAVE && r_error == ERR_SLAVE))
        else $error("slave status");
    // a host word for disk is only produced with a buffer write
    a_word_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && n_out.disk_word_valid) |-> w_ram_we)
        else $error("word without buffer write");
    // entering identify mode raises DRQ
    a_ident_drq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && n_ident && !r_ident) |=> (r_status == ST_DRQ))
        else $error("identify without DRQ");
endmodule
